/* src/cmc_pkg.sv */
package cmc_pkg;

  localparam int unsigned READ_DEPTH_DEFAULT = 1024;

  // Result queue: a final position can push two results in one cycle.
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // Item kinds
  localparam logic ITEM_LOAD  = 1'b0;
  localparam logic ITEM_ALIGN = 1'b1;

  // Edit ops
  localparam logic [2:0] OP_MATCH    = 3'd0;
  localparam logic [2:0] OP_MISMATCH = 3'd1;
  localparam logic [2:0] OP_INSERT   = 3'd2;
  localparam logic [2:0] OP_DELETE   = 3'd3;
  localparam logic [2:0] OP_METHYL   = 3'd4;

  // Methylation tags
  localparam logic [2:0] TAG_NONE = 3'd0;
  localparam logic [2:0] TAG_LZ   = 3'd1;
  localparam logic [2:0] TAG_UZ   = 3'd2;
  localparam logic [2:0] TAG_UU   = 3'd3;
  localparam logic [2:0] TAG_LU   = 3'd4;

  // Second-read base codes
  localparam logic [2:0] CODE_A = 3'd0;
  localparam logic [2:0] CODE_C = 3'd1;
  localparam logic [2:0] CODE_G = 3'd2;

  // ASCII consensus characters
  localparam logic [7:0] CHAR_C = 8'h43;
  localparam logic [7:0] CHAR_G = 8'h47;
  localparam logic [7:0] CHAR_T = 8'h54;

  typedef struct packed {
    logic       op;
    logic [2:0] read2_code;
    logic [2:0] edit_op;
    logic [7:0] consensus_char;
    logic       is_final;
  } in_item_t;

  typedef struct packed {
    logic [7:0] base_out;
    logic [2:0] op_out;
    logic [2:0] tag;
    logic       fault;
    logic       run_end;
  } out_item_t;

  typedef struct packed {
    logic [7:0] base1;
    logic [2:0] op1;
    logic [2:0] tag;
    logic [2:0] op2;
  } judge_t;

  typedef struct packed {
    logic [FIFO_CW-1:0] count;
    logic               room;
  } fifo_status_t;

endpackage

/* src/cmc_read_store.sv */
module cmc_read_store #(
  parameter int unsigned READ_DEPTH = cmc_pkg::READ_DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                wr_en,
  input  logic [$clog2(READ_DEPTH)-1:0]       wr_addr,
  input  logic [2:0]                          wr_code,
  input  logic [$clog2(READ_DEPTH+1):0]       rd_addr_a,
  input  logic [$clog2(READ_DEPTH+1):0]       rd_addr_b,
  output logic [2:0]                          rd_code_a,
  output logic [2:0]                          rd_code_b
);
  import cmc_pkg::*;

  localparam int unsigned AW = $clog2(READ_DEPTH);
  localparam int unsigned RW = $clog2(READ_DEPTH + 1) + 1;
  localparam logic [RW-1:0] DEPTH_R = RW'(READ_DEPTH);

  logic [2:0] mem [READ_DEPTH];

  logic          in_range_a, in_range_b;
  logic [AW-1:0] idx_a, idx_b;
  logic          hit_a, hit_b;

  assign in_range_a = rd_addr_a < DEPTH_R;
  assign in_range_b = rd_addr_b < DEPTH_R;
  assign idx_a      = rd_addr_a[AW-1:0];
  assign idx_b      = rd_addr_b[AW-1:0];
  // write-through so a read in the same cycle sees the new code
  assign hit_a      = wr_en && in_range_a && (idx_a == wr_addr);
  assign hit_b      = wr_en && in_range_b && (idx_b == wr_addr);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_code;
    end
    if (hit_a) begin
      rd_code_a <= wr_code;
    end else if (in_range_a) begin
      rd_code_a <= mem[idx_a];
    end else begin
      rd_code_a <= CODE_A;
    end
    if (hit_b) begin
      rd_code_b <= wr_code;
    end else if (in_range_b) begin
      rd_code_b <= mem[idx_b];
    end else begin
      rd_code_b <= CODE_A;
    end
  end

endmodule

/* src/cmc_pair_judge.sv */
module cmc_pair_judge (
  input  logic [2:0]      op1,
  input  logic [7:0]      char1,
  input  logic [2:0]      op2,
  input  logic [7:0]      char2,
  input  logic [2:0]      code1,
  input  logic [2:0]      code2,
  output cmc_pkg::judge_t judge
);
  import cmc_pkg::*;

  logic no_indel;

  assign no_indel = (op1 != OP_INSERT) && (op1 != OP_DELETE) &&
                    (op2 != OP_INSERT) && (op2 != OP_DELETE);

  always_comb begin
    judge.base1 = char1;
    judge.op1   = op1;
    judge.tag   = TAG_NONE;
    judge.op2   = op2;
    if (no_indel) begin
      if (op1 == OP_MATCH && op2 == OP_MATCH && char1 == CHAR_C && char2 == CHAR_G) begin
        judge.tag = TAG_LZ;
      end else if (op1 == OP_MISMATCH && op2 == OP_MISMATCH && char1 == CHAR_T &&
                   char2 == CHAR_G && code1 == CODE_C && code2 == CODE_A) begin
        judge.base1 = CHAR_C;
        judge.tag   = TAG_UZ;
        judge.op1   = OP_METHYL;
        judge.op2   = OP_METHYL;
      end else if (op1 == OP_MISMATCH && op2 == OP_MATCH && char1 == CHAR_T &&
                   char2 == CHAR_G && code1 == CODE_C && code2 == CODE_G) begin
        judge.base1 = CHAR_C;
        judge.tag   = TAG_UU;
        judge.op1   = OP_METHYL;
      end else if (op1 == OP_MATCH && op2 == OP_MISMATCH && char1 == CHAR_C &&
                   char2 == CHAR_G && code1 == CODE_C && code2 == CODE_A) begin
        judge.tag = TAG_LU;
        judge.op2 = OP_METHYL;
      end
    end
  end

endmodule

/* src/cmc_result_fifo.sv */
module cmc_result_fifo (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [1:0]             push_cnt,
  input  cmc_pkg::out_item_t     push_d0,
  input  cmc_pkg::out_item_t     push_d1,
  output logic                   out_valid,
  input  logic                   out_stall,
  output cmc_pkg::out_item_t     out_data,
  output cmc_pkg::fifo_status_t  status
);
  import cmc_pkg::*;

  out_item_t          entries [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr, rd_ptr;
  logic [FIFO_AW-1:0] wr_ptr_next, rd_ptr_next, wr_ptr_plus1;
  logic [FIFO_CW-1:0] count, count_next;
  logic               pop;

  assign out_valid    = count != '0;
  assign out_data     = entries[rd_ptr];
  assign pop          = out_valid && !out_stall;
  assign wr_ptr_plus1 = wr_ptr + FIFO_AW'(1);

  assign wr_ptr_next = wr_ptr + FIFO_AW'(push_cnt);
  assign rd_ptr_next = rd_ptr + FIFO_AW'(pop);
  assign count_next  = count + FIFO_CW'(push_cnt) - FIFO_CW'(pop);

  // room for a two-result push regardless of this cycle's pop
  assign status.count = count;
  assign status.room  = count <= FIFO_CW'(FIFO_DEPTH - 2);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      entries[wr_ptr] <= push_d0;
    end
    if (push_cnt == 2'd2) begin
      entries[wr_ptr_plus1] <= push_d1;
    end
  end

endmodule

/* src/cpg_methylation_converter_unit.sv */
// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall   cmc_pkg::in_item_t   (load or alignment position)
// out       output     out_valid / out_stall cmc_pkg::out_item_t  (tagged position)
// cfg       input      cfg_we               cfg_data             (read2_is_reference)
//
// One item per cycle while in_stall is low: an input transfer lands in the input register
// and is processed once the result queue has room. A position's result is queued when the
// next position of its run is processed (a final position queues its own result too).
// rst is synchronous, active high; it clears control state. The read store is never
// cleared: reads at or past the load count return code A. in_stall rises only while an
// item waits and the 4-entry result queue has fewer than two free entries (out_stall).
module cpg_methylation_converter_unit #(
  parameter int unsigned READ_DEPTH = cmc_pkg::READ_DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  cmc_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output cmc_pkg::out_item_t out_data
);
  import cmc_pkg::*;

  localparam int unsigned AW = $clog2(READ_DEPTH);
  localparam int unsigned CW = $clog2(READ_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(READ_DEPTH);

  // config register
  logic read2_is_reference;

  // input register
  logic     stage_full;
  in_item_t stage_item;

  // run state
  logic [CW-1:0] load_address, load_address_next;
  logic [CW-1:0] read2_pointer, read2_pointer_next;
  logic          held_valid, held_valid_next;
  logic [2:0]    held_op, held_op_next;
  logic [7:0]    held_char, held_char_next;
  logic          error_seen, error_seen_next;

  logic          advance, is_load, is_align, err_now, step, store_we;
  logic [CW:0]   rd_addr_a, rd_addr_b, ptr_plus1;
  logic [2:0]    raw_a, raw_b, code1, code2, op_carry;
  judge_t        judge;
  fifo_status_t  fifo_status;
  logic [1:0]    push_cnt;
  out_item_t     push_d0, push_d1, pair_res, final_res;

  // ---------------------------------------------------------------------
  // Input register: refills on the same edge the held item is processed.
  // ---------------------------------------------------------------------
  assign advance  = stage_full && fifo_status.room;
  assign in_stall = stage_full && !fifo_status.room;
  assign is_load  = advance && (stage_item.op == ITEM_LOAD);
  assign is_align = advance && (stage_item.op == ITEM_ALIGN);

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      stage_full <= 1'b1;
    end else if (advance) begin
      stage_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      stage_item <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      read2_is_reference <= 1'b0;
    end else if (cfg_we) begin
      read2_is_reference <= cfg_data;
    end
  end

  // ---------------------------------------------------------------------
  // Read store. Both ports are re-read every cycle, port a at the pointer
  // value being loaded and port b one entry past it, so the registered codes
  // always track the current pointer and any load that lands on it.
  // ---------------------------------------------------------------------
  assign store_we = is_load && (load_address < DEPTH_C);
  assign rd_addr_a = {1'b0, read2_pointer_next};
  assign rd_addr_b = {1'b0, read2_pointer_next} + (CW+1)'(1);

  cmc_read_store #(
    .READ_DEPTH(READ_DEPTH)
  ) u_store (
    .clk       (clk),
    .wr_en     (store_we),
    .wr_addr   (load_address[AW-1:0]),
    .wr_code   (stage_item.read2_code),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_code_a (raw_a),
    .rd_code_b (raw_b)
  );

  // entries at or past the load count read as A
  assign ptr_plus1 = {1'b0, read2_pointer} + (CW+1)'(1);
  assign code1 = (read2_pointer < load_address) ? raw_a : CODE_A;
  assign code2 = (ptr_plus1 < {1'b0, load_address}) ? raw_b : CODE_A;

  // ---------------------------------------------------------------------
  // Pair check: held position against the incoming one.
  // ---------------------------------------------------------------------
  cmc_pair_judge u_judge (
    .op1   (held_op),
    .char1 (held_char),
    .op2   (stage_item.edit_op),
    .char2 (stage_item.consensus_char),
    .code1 (code1),
    .code2 (code2),
    .judge (judge)
  );

  // invalid op counts toward fault on the results of its own cycle
  assign err_now = error_seen || (stage_item.edit_op > OP_METHYL);

  // pointer step follows the judged held op
  assign step = (judge.op1 == OP_MATCH) || (judge.op1 == OP_MISMATCH) ||
                (judge.op1 == OP_METHYL) ||
                (judge.op1 == OP_DELETE && read2_is_reference) ||
                (judge.op1 == OP_INSERT && !read2_is_reference);

  assign op_carry = held_valid ? judge.op2 : stage_item.edit_op;

  always_comb begin
    pair_res.base_out = judge.base1;
    pair_res.op_out   = judge.op1;
    pair_res.tag      = judge.tag;
    pair_res.fault    = err_now;
    pair_res.run_end  = 1'b0;

    final_res.base_out = stage_item.consensus_char;
    final_res.op_out   = op_carry;
    final_res.tag      = TAG_NONE;
    final_res.fault    = err_now;
    final_res.run_end  = 1'b1;
  end

  always_comb begin
    push_cnt = 2'd0;
    push_d0  = pair_res;
    push_d1  = final_res;
    if (is_align) begin
      if (held_valid && stage_item.is_final) begin
        push_cnt = 2'd2;
      end else if (held_valid) begin
        push_cnt = 2'd1;
      end else if (stage_item.is_final) begin
        push_cnt = 2'd1;
        push_d0  = final_res;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Run state update
  // ---------------------------------------------------------------------
  always_comb begin
    load_address_next  = load_address;
    read2_pointer_next = read2_pointer;
    held_valid_next    = held_valid;
    held_op_next       = held_op;
    held_char_next     = held_char;
    error_seen_next    = error_seen;
    if (store_we) begin
      load_address_next = load_address + CW'(1);
    end
    if (is_align) begin
      if (stage_item.is_final) begin
        // run over: next run loads afresh
        load_address_next  = '0;
        read2_pointer_next = '0;
        held_valid_next    = 1'b0;
        held_op_next       = OP_MATCH;
        held_char_next     = '0;
        error_seen_next    = 1'b0;
      end else begin
        if (held_valid && step && (read2_pointer < DEPTH_C)) begin
          read2_pointer_next = read2_pointer + CW'(1);
        end
        held_valid_next = 1'b1;
        held_op_next    = op_carry;
        held_char_next  = stage_item.consensus_char;
        error_seen_next = err_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_address  <= '0;
      read2_pointer <= '0;
      held_valid    <= 1'b0;
      held_op       <= OP_MATCH;
      held_char     <= '0;
      error_seen    <= 1'b0;
    end else begin
      load_address  <= load_address_next;
      read2_pointer <= read2_pointer_next;
      held_valid    <= held_valid_next;
      held_op       <= held_op_next;
      held_char     <= held_char_next;
      error_seen    <= error_seen_next;
    end
  end

  // ---------------------------------------------------------------------
  // Result queue
  // ---------------------------------------------------------------------
  cmc_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_cnt  (push_cnt),
    .push_d0   (push_d0),
    .push_d1   (push_d1),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .status    (fifo_status)
  );

`ifndef NO_ASSERTIONS
  a_fifo_bound: assert property (@(posedge clk) disable iff (rst)
    fifo_status.count <= FIFO_CW'(FIFO_DEPTH))
    else $error("result queue over capacity");

  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    read2_pointer <= DEPTH_C)
    else $error("read pointer beyond store depth");

  a_load_bound: assert property (@(posedge clk) disable iff (rst)
    load_address <= DEPTH_C)
    else $error("load count beyond store depth");

  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    (is_align && stage_item.is_final) |=>
      (!held_valid && read2_pointer == '0 && load_address == '0 && !error_seen))
    else $error("run state not cleared after final position");
`endif

endmodule
